FILE: hw/rtl/falu_pkg.sv
// ----------------------------------------------------------------------------
// falu_pkg
// Shared types and constants of the signed fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
package falu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  // remainder of a magnitude divide stays below the divisor, at most 2^31 - 1
  localparam int unsigned REM_W  = DATA_W - 1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic signed [DATA_W-1:0] word_t;

  // per-item status that rides along the divider array
  typedef struct packed {
    word_t result;
    logic  overflow;
    logic  div_by_zero;
    logic  less;
    logic  equal;
    logic  greater;
    logic  is_div;
    logic  neg;
  } tag_t;

  typedef struct packed {
    word_t result;
    logic  overflow;
    logic  div_by_zero;
    logic  less;
    logic  equal;
    logic  greater;
  } rsp_t;

endpackage

FILE: hw/rtl/falu_chan_if.sv
// ----------------------------------------------------------------------------
// falu channel interfaces
// Request and response channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface falu_req_if;
  import falu_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] action;
  word_t           operand_a;
  word_t           operand_b;
  logic            b_is_integer;

  modport source (output valid, action, operand_a, operand_b, b_is_integer, input ready);
  modport sink   (input valid, action, operand_a, operand_b, b_is_integer, output ready);
endinterface

interface falu_rsp_if;
  import falu_pkg::*;

  logic  valid;
  logic  ready;
  word_t result;
  logic  overflow;
  logic  div_by_zero;
  logic  less;
  logic  equal;
  logic  greater;

  modport source (output valid, result, overflow, div_by_zero, less, equal, greater,
                  input ready);
  modport sink   (input valid, result, overflow, div_by_zero, less, equal, greater,
                  output ready);
endinterface

FILE: hw/rtl/falu_front.sv
// ----------------------------------------------------------------------------
// falu_front
// Input register, operand scaling, add / subtract / multiply and compare,
// and the setup of the magnitude divide.
// ----------------------------------------------------------------------------
module falu_front #(
  parameter  int unsigned FRAC_BITS = 8,
  localparam int unsigned DIV_W     = falu_pkg::DATA_W + FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  falu_req_if.sink                     in_req,
  output logic                         v_o,
  output falu_pkg::tag_t               tag_o,
  output logic [DIV_W-1:0]             dq_o,
  output logic [falu_pkg::DATA_W-1:0]  dvs_o
);
  import falu_pkg::*;

  localparam int unsigned BS_W   = DATA_W + FRAC_BITS;
  localparam int unsigned SUM_W  = BS_W + 1;
  localparam int unsigned PROD_W = 2 * DATA_W;

  // stage 1: input register
  logic  s1_v_r;
  op_t   s1_op_r;
  word_t s1_a_r;
  word_t s1_b_r;
  logic  s1_int_r;

  // stage 2: scaled operands, sum, product, divide setup
  logic                     s2_v_r;
  op_t                      s2_op_r;
  logic [SUM_W-1:0]         s2_sum_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                     s2_int_r;
  logic                     s2_less_r;
  logic                     s2_equal_r;
  logic                     s2_greater_r;
  logic                     s2_dz_r;
  logic                     s2_neg_r;
  logic [DIV_W-1:0]         s2_dvd_r;
  logic [DATA_W-1:0]        s2_dvs_r;

  // stage 3: early result
  logic              s3_v_r;
  tag_t              s3_tag_r;
  logic [DIV_W-1:0]  s3_dvd_r;
  logic [DATA_W-1:0] s3_dvs_r;

  logic signed [BS_W-1:0]   a_ext;
  logic signed [BS_W-1:0]   bs;
  logic [SUM_W-1:0]         sum_nxt;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic [DIV_W-1:0]         dvd_nxt;
  logic signed [PROD_W-1:0] mres;
  logic                     sum_ovf;
  logic                     mul_ovf;
  tag_t                     tag_nxt;

  // no request is taken while reset is held
  assign in_req.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // stage 2 logic
  always_comb begin
    a_ext = {{FRAC_BITS{s1_a_r[DATA_W-1]}}, s1_a_r};
    bs    = s1_int_r ? {s1_b_r, {FRAC_BITS{1'b0}}}
                     : {{FRAC_BITS{s1_b_r[DATA_W-1]}}, s1_b_r};
    if (s1_op_r == OP_SUB) begin
      sum_nxt = {a_ext[BS_W-1], a_ext} - {bs[BS_W-1], bs};
    end else begin
      sum_nxt = {a_ext[BS_W-1], a_ext} + {bs[BS_W-1], bs};
    end
    prod_nxt = s1_a_r * s1_b_r;
    a_mag    = s1_a_r[DATA_W-1] ? DATA_W'(-s1_a_r) : DATA_W'(s1_a_r);
    b_mag    = s1_b_r[DATA_W-1] ? DATA_W'(-s1_b_r) : DATA_W'(s1_b_r);
    // integer divisor already carries the scale, so the dividend stays unshifted
    dvd_nxt  = s1_int_r ? {{FRAC_BITS{1'b0}}, a_mag} : {a_mag, {FRAC_BITS{1'b0}}};
  end

  // stage 3 logic
  always_comb begin
    mres    = s2_int_r ? s2_prod_r : (s2_prod_r >>> FRAC_BITS);
    sum_ovf = s2_sum_r[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){s2_sum_r[DATA_W-1]}};
    mul_ovf = mres[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){mres[DATA_W-1]}};
    tag_nxt = '0;
    tag_nxt.less        = s2_less_r;
    tag_nxt.equal       = s2_equal_r;
    tag_nxt.greater     = s2_greater_r;
    tag_nxt.neg         = s2_neg_r;
    case (s2_op_r)
      OP_ADD, OP_SUB: begin
        tag_nxt.result   = s2_sum_r[DATA_W-1:0];
        tag_nxt.overflow = sum_ovf;
      end
      OP_MUL: begin
        tag_nxt.result   = mres[DATA_W-1:0];
        tag_nxt.overflow = mul_ovf;
      end
      default: begin
        tag_nxt.is_div      = 1'b1;
        tag_nxt.div_by_zero = s2_dz_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r      <= op_t'(in_req.action);
      s1_a_r       <= in_req.operand_a;
      s1_b_r       <= in_req.operand_b;
      s1_int_r     <= in_req.b_is_integer;
      s2_op_r      <= s1_op_r;
      s2_sum_r     <= sum_nxt;
      s2_prod_r    <= prod_nxt;
      s2_int_r     <= s1_int_r;
      s2_less_r    <= a_ext < bs;
      s2_equal_r   <= a_ext == bs;
      s2_greater_r <= a_ext > bs;
      s2_dz_r      <= s1_b_r == '0;
      s2_neg_r     <= s1_a_r[DATA_W-1] ^ s1_b_r[DATA_W-1];
      s2_dvd_r     <= dvd_nxt;
      s2_dvs_r     <= b_mag;
      s3_tag_r     <= tag_nxt;
      s3_dvd_r     <= s2_dvd_r;
      s3_dvs_r     <= s2_dvs_r;
    end
  end

  assign v_o   = s3_v_r;
  assign tag_o = s3_tag_r;
  assign dq_o  = s3_dvd_r;
  assign dvs_o = s3_dvs_r;

endmodule

FILE: hw/rtl/falu_dstep.sv
// ----------------------------------------------------------------------------
// falu_dstep
// One stage of the restoring divider: develops one quotient bit.
// ----------------------------------------------------------------------------
module falu_dstep #(
  parameter int unsigned DIV_W = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         v_i,
  input  falu_pkg::tag_t               tag_i,
  input  logic [falu_pkg::REM_W-1:0]   rem_i,
  input  logic [DIV_W-1:0]             dq_i,
  input  logic [falu_pkg::DATA_W-1:0]  dvs_i,
  output logic                         v_o,
  output falu_pkg::tag_t               tag_o,
  output logic [falu_pkg::REM_W-1:0]   rem_o,
  output logic [DIV_W-1:0]             dq_o,
  output logic [falu_pkg::DATA_W-1:0]  dvs_o
);
  import falu_pkg::*;

  logic              v_r;
  tag_t              tag_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dq_r;
  logic [DATA_W-1:0] dvs_r;

  logic [DATA_W-1:0] trial;
  logic [DATA_W-1:0] diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  dq_nxt;

  // dividend bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    trial   = {rem_i, dq_i[DIV_W-1]};
    ge      = trial >= dvs_i;
    diff    = trial - dvs_i;
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    dq_nxt  = {dq_i[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r <= tag_i;
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign v_o   = v_r;
  assign tag_o = tag_r;
  assign rem_o = rem_r;
  assign dq_o  = dq_r;
  assign dvs_o = dvs_r;

endmodule

FILE: hw/rtl/falu_back.sv
// ----------------------------------------------------------------------------
// falu_back
// Quotient sign and range fix-up, result select and two-entry output queue
// that drives the response channel and the pipeline advance.
// ----------------------------------------------------------------------------
module falu_back #(
  parameter int unsigned DIV_W = 40
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         v_i,
  input  falu_pkg::tag_t               tag_i,
  input  logic [DIV_W-1:0]             dq_i,
  input  logic [falu_pkg::REM_W-1:0]   rem_i,
  input  logic [falu_pkg::DATA_W-1:0]  dvs_i,
  output logic                         adv,
  falu_rsp_if.source                   out_rsp
);
  import falu_pkg::*;

  localparam logic [1:0] Q_EMPTY = 2'd0;
  localparam logic [1:0] Q_ONE   = 2'd1;
  localparam logic [1:0] Q_FULL  = 2'd2;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  rsp_t       q0_r;
  rsp_t       q1_r;

  logic [DIV_W:0] q_ext;
  logic [DIV_W:0] qs;
  logic           div_ovf;
  rsp_t           rsp_nxt;
  logic           push;
  logic           pop;

  always_comb begin
    q_ext   = {1'b0, dq_i};
    qs      = tag_i.neg ? (~q_ext + 1'b1) : q_ext;
    div_ovf = qs[DIV_W:DATA_W-1] != {(DIV_W-DATA_W+2){qs[DATA_W-1]}};
    rsp_nxt.less        = tag_i.less;
    rsp_nxt.equal       = tag_i.equal;
    rsp_nxt.greater     = tag_i.greater;
    rsp_nxt.div_by_zero = tag_i.div_by_zero;
    if (!tag_i.is_div) begin
      rsp_nxt.result   = tag_i.result;
      rsp_nxt.overflow = tag_i.overflow;
    end else if (tag_i.div_by_zero) begin
      rsp_nxt.result   = '0;
      rsp_nxt.overflow = 1'b0;
    end else begin
      rsp_nxt.result   = qs[DATA_W-1:0];
      rsp_nxt.overflow = div_ovf;
    end
  end

  // pipeline moves whenever the queue has a free slot
  assign adv  = cnt_r != Q_FULL;
  assign push = adv && v_i;
  assign pop  = out_rsp.valid && out_rsp.ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= Q_EMPTY;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0_r <= (cnt_r == Q_FULL) ? q1_r : rsp_nxt;
    end else if (push && cnt_r == Q_EMPTY) begin
      q0_r <= rsp_nxt;
    end
    if (push && !pop && cnt_r == Q_ONE) begin
      q1_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid       = cnt_r != Q_EMPTY;
  assign out_rsp.result      = q0_r.result;
  assign out_rsp.overflow    = q0_r.overflow;
  assign out_rsp.div_by_zero = q0_r.div_by_zero;
  assign out_rsp.less        = q0_r.less;
  assign out_rsp.equal       = q0_r.equal;
  assign out_rsp.greater     = q0_r.greater;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == Q_EMPTY || cnt_r == Q_ONE || cnt_r == Q_FULL)
    else $error("output queue count out of range");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && out_rsp.div_by_zero |-> out_rsp.result == '0 && !out_rsp.overflow)
    else $error("divide by zero result not forced to zero");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> $onehot({out_rsp.less, out_rsp.equal, out_rsp.greater}))
    else $error("compare flags not one-hot");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_i && dvs_i != '0 |-> {1'b0, rem_i} < dvs_i)
    else $error("final remainder not below divisor");

endmodule

FILE: hw/rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed fixed-point add, subtract, multiply and divide with compare flags.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one response per request, in order.
// Every request, whatever its operation, takes the same path from its
// acceptance to its response showing as valid, passing in order through three
// stages of input register, operand scaling with the 32x32 multiplier, and
// result select, then one stage per quotient bit of the 32 + FRAC_BITS bit
// restoring divider array, then the output queue. The two-entry output queue
// keeps requests flowing while a response waits; requests stall only when
// both entries are occupied. Operand B can be raw fixed point or an integer
// scaled by 2^FRAC_BITS; results are the low 32 bits of the exact value with
// an overflow flag, and a divide by zero returns 0 with div_by_zero set.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  falu_req_if.sink   in_req,
  falu_rsp_if.source out_rsp
);
  import falu_pkg::*;

  localparam int unsigned DIV_W = DATA_W + FRAC_BITS;

  logic              adv;
  logic              v_c   [DIV_W+1];
  tag_t              tag_c [DIV_W+1];
  logic [REM_W-1:0]  rem_c [DIV_W+1];
  logic [DIV_W-1:0]  dq_c  [DIV_W+1];
  logic [DATA_W-1:0] dvs_c [DIV_W+1];

  falu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_req (in_req),
    .v_o    (v_c[0]),
    .tag_o  (tag_c[0]),
    .dq_o   (dq_c[0]),
    .dvs_o  (dvs_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar i = 0; i < DIV_W; i++) begin : g_step
    falu_dstep #(.DIV_W(DIV_W)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .v_i   (v_c[i]),
      .tag_i (tag_c[i]),
      .rem_i (rem_c[i]),
      .dq_i  (dq_c[i]),
      .dvs_i (dvs_c[i]),
      .v_o   (v_c[i+1]),
      .tag_o (tag_c[i+1]),
      .rem_o (rem_c[i+1]),
      .dq_o  (dq_c[i+1]),
      .dvs_o (dvs_c[i+1])
    );
  end

  falu_back #(.DIV_W(DIV_W)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .v_i     (v_c[DIV_W]),
    .tag_i   (tag_c[DIV_W]),
    .dq_i    (dq_c[DIV_W]),
    .rem_i   (rem_c[DIV_W]),
    .dvs_i   (dvs_c[DIV_W]),
    .adv     (adv),
    .out_rsp (out_rsp)
  );

endmodule

FILE: tb/fixed_point_q24_8_alu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb
// Drives directed corner cases and then random Q24.8 requests through the
// ALU. The sender works in bursts and the receiver stalls on its own pattern.
// Every response is checked field by field, in order, against a 64-bit
// evaluation of the exact arithmetic.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_tb;
  import falu_pkg::*;

  localparam int unsigned FRAC_BITS  = 8;
  localparam int          RAND_ITEMS = 700;

  typedef struct {
    op_t   action;
    word_t operand_a;
    word_t operand_b;
    logic  b_is_integer;
  } alu_req_t;

  logic clk = 1'b0;
  logic rst_n;

  falu_req_if req_if ();
  falu_rsp_if rsp_if ();

  fixed_point_q24_8_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  alu_req_t request_backlog[$];
  rsp_t     outstanding_rsp[$];
  alu_req_t on_bus;

  int total_requests;
  int accepted_cnt;
  int checked_cnt;
  int mismatches;
  int op_seen[4];
  int ovf_seen;
  int dz_seen;
  int eq_seen;

  // exact arithmetic in 64 bits, low word returned
  function automatic rsp_t q24_8_eval(alu_req_t r);
    longint a, b, bs, v;
    rsp_t   rsp;
    a  = longint'(r.operand_a);
    b  = longint'(r.operand_b);
    bs = r.b_is_integer ? (b <<< FRAC_BITS) : b;
    rsp.div_by_zero = 1'b0;
    case (r.action)
      OP_ADD: v = a + bs;
      OP_SUB: v = a - bs;
      OP_MUL: v = r.b_is_integer ? a * b : ((a * b) >>> FRAC_BITS);
      default: begin
        if (b == 0) begin
          rsp.div_by_zero = 1'b1;
          v = 0;
        end else if (r.b_is_integer) begin
          v = a / b;
        end else begin
          v = (a <<< FRAC_BITS) / b;
        end
      end
    endcase
    // fits in 32 signed bits only when bits 63..31 all agree
    rsp.overflow = ((v >>> 31) != 0) && ((v >>> 31) != -1);
    rsp.result   = v[31:0];
    rsp.less     = a < bs;
    rsp.equal    = a == bs;
    rsp.greater  = a > bs;
    return rsp;
  endfunction

  task automatic push_req(op_t op, word_t a, word_t b, logic is_int);
    alu_req_t r;
    r.action       = op;
    r.operand_a    = a;
    r.operand_b    = b;
    r.b_is_integer = is_int;
    request_backlog.push_back(r);
  endtask

  function automatic word_t rand_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return word_t'(32'h7FFF_FFFF);
      2: return word_t'(32'h8000_0000);
      3: return word_t'($urandom_range(0, 2048)) - word_t'(1024);
      4: return $urandom_range(0, 1) ? word_t'(1) : word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sender: requests in bursts with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        rsp_t p;
        p = q24_8_eval(on_bus);
        outstanding_rsp.push_back(p);
        accepted_cnt++;
        op_seen[on_bus.action]++;
        if (p.overflow) ovf_seen++;
        if (p.div_by_zero) dz_seen++;
        if (p.equal) eq_seen++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          on_bus = request_backlog.pop_front();
          req_if.action       <= on_bus.action;
          req_if.operand_a    <= on_bus.operand_a;
          req_if.operand_b    <= on_bus.operand_b;
          req_if.b_is_integer <= on_bus.b_is_integer;
          req_if.valid        <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready pattern switches between modes every so often
  int ready_mode;
  int mode_left;
  int ready_ctr;
  rsp_t got_rsp;
  rsp_t want_rsp;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 160);
    end else begin
      mode_left--;
    end
    ready_ctr++;
    case (ready_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= (ready_ctr % 4) != 0;
      2: rsp_if.ready <= 1'($urandom_range(0, 1));
      default: rsp_if.ready <= (ready_ctr % 32) < 8;
    endcase

    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got_rsp.result      = rsp_if.result;
      got_rsp.overflow    = rsp_if.overflow;
      got_rsp.div_by_zero = rsp_if.div_by_zero;
      got_rsp.less        = rsp_if.less;
      got_rsp.equal       = rsp_if.equal;
      got_rsp.greater     = rsp_if.greater;
      if (outstanding_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request pending, expected none, actual %0h",
                 $time, got_rsp.result);
      end else begin
        want_rsp = outstanding_rsp.pop_front();
        check_field("result", want_rsp.result, got_rsp.result);
        check_field("overflow", want_rsp.overflow, got_rsp.overflow);
        check_field("div_by_zero", want_rsp.div_by_zero, got_rsp.div_by_zero);
        check_field("less", want_rsp.less, got_rsp.less);
        check_field("equal", want_rsp.equal, got_rsp.equal);
        check_field("greater", want_rsp.greater, got_rsp.greater);
      end
      checked_cnt++;
    end
  end

  // stimulus and end of run
  initial begin
    word_t    a;
    word_t    b;
    logic     is_int;

    rst_n = 1'b0;

    // directed corners
    push_req(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    push_req(OP_ADD, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_req(OP_ADD, 32'sh0, 32'sh0, 1'b0);
    push_req(OP_SUB, 32'sh8000_0000, 32'sh1, 1'b0);
    push_req(OP_SUB, 32'sh100, 32'sh1, 1'b1);
    push_req(OP_ADD, 32'sh5, 32'sh7FFF_FFFF, 1'b1);
    push_req(OP_ADD, 32'sh5, 32'sh8000_0000, 1'b1);
    push_req(OP_MUL, -32'sh1, 32'sh1, 1'b0);
    push_req(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    push_req(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_req(OP_MUL, 32'sh300, 32'sh5, 1'b1);
    push_req(OP_MUL, 32'sh8000_0000, -32'sh1, 1'b1);
    push_req(OP_MUL, -32'sh180, 32'sh80, 1'b0);
    push_req(OP_MUL, 32'sh1, 32'sh1, 1'b0);
    push_req(OP_DIV, 32'sh100, 32'sh0, 1'b0);
    push_req(OP_DIV, 32'sh8000_0000, 32'sh0, 1'b1);
    push_req(OP_DIV, 32'sh8000_0000, -32'sh1, 1'b1);
    push_req(OP_DIV, 32'sh8000_0000, -32'sh1, 1'b0);
    push_req(OP_DIV, 32'sh100, 32'sh300, 1'b0);
    push_req(OP_DIV, -32'sh700, 32'sh2, 1'b1);
    push_req(OP_DIV, -32'sh1, 32'sh300, 1'b0);
    push_req(OP_DIV, 32'sh7FFF_FFFF, 32'sh1, 1'b0);
    push_req(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_req(OP_ADD, -32'sh200, -32'sh2, 1'b1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      a      = rand_operand();
      b      = rand_operand();
      is_int = 1'($urandom_range(0, 1));
      // small integers keep the scaled operand in range most of the time
      if (is_int && $urandom_range(0, 1)) begin
        b = word_t'($urandom_range(0, 10000)) - word_t'(5000);
      end
      // force some equal compares
      if ($urandom_range(0, 7) == 0) begin
        if (is_int) begin
          b = word_t'($urandom_range(0, 1 << 20)) - word_t'(1 << 19);
          a = b <<< FRAC_BITS;
        end else begin
          b = a;
        end
      end
      push_req(op_t'($urandom_range(0, 3)), a, b, is_int);
    end
    total_requests = request_backlog.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_requests) @(posedge clk);
    while (outstanding_rsp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d requests: add %0d, sub %0d, mul %0d, div %0d",
             accepted_cnt, op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_MUL],
             op_seen[OP_DIV]);
    $display("responses checked %0d: overflow %0d, divide by zero %0d, equal %0d",
             checked_cnt, ovf_seen, dz_seen, eq_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d responses still pending", outstanding_rsp.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
